/* hdl/quantized_global_average_pool_core_defines.svh */
// Assertion macros shared by the pooling core modules.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef QUANTIZED_GLOBAL_AVERAGE_POOL_CORE_DEFINES_SVH
`define QUANTIZED_GLOBAL_AVERAGE_POOL_CORE_DEFINES_SVH

// Same-cycle implication
`define QGAP_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define QGAP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/qgap_pkg.sv */
// Shared constants, register codes and structs of the pooling core.
// No dependencies; imported by every module of the block.
package qgap_pkg;

    localparam int MAX_CHANNELS = 256;
    localparam int ADDR_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    // Queue between accumulate front and requantize back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_BIAS             = 3'd0,
        REG_SCALE_MULTIPLIER = 3'd1,
        REG_ROUNDING_TERM    = 3'd2,
        REG_SHIFT_AMOUNT     = 3'd3,
        REG_CLAMP_LOW        = 3'd4,
        REG_CLAMP_HIGH       = 3'd5,
        REG_ZERO_OFFSET      = 3'd6
    } qgap_reg_t;

    // Requantization settings used by the back end
    typedef struct packed {
        logic [30:0]        scale_multiplier;
        logic [62:0]        rounding_term;
        logic [5:0]         shift_amount;
        logic signed [8:0]  clamp_low;
        logic signed [8:0]  clamp_high;
        logic [7:0]         zero_offset;
    } qgap_cfg_t;

    // One finished channel sum waiting for requantization
    typedef struct packed {
        logic [7:0]  channel;
        logic [31:0] acc;
    } qgap_entry_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic               not_empty;
        logic [Q_CNT_W-1:0] level;
    } qgap_qstat_t;

endpackage

/* hdl/qgap_fifo.sv */
// Short word queue decoupling the accumulate front from the requantize back.
// Depends on qgap_pkg and the assertion macro header.
`include "quantized_global_average_pool_core_defines.svh"

module qgap_fifo
    import qgap_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  qgap_entry_t push_entry,
    input  logic        pop,
    output qgap_entry_t head_entry,
    output qgap_qstat_t status
);

    qgap_entry_t        slots_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_next;

    // Pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == Q_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == Q_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head_entry       = slots_reg[rd_ptr_reg];
    assign status.not_empty = (count_reg != '0);
    assign status.level     = count_reg;

    `QGAP_ASSERT(a_no_push_full, push && !pop, count_reg != Q_CNT_W'(Q_DEPTH), "push into full queue")
    `QGAP_ASSERT(a_no_pop_empty, pop, count_reg != '0, "pop from empty queue")
    `QGAP_ASSERT(a_count_range, 1'b1, count_reg <= Q_CNT_W'(Q_DEPTH), "queue count out of range")

endmodule

/* hdl/qgap_accum.sv */
// Front end: accepts sample words and keeps the per-channel running sums.
// Depends on qgap_pkg and the assertion macro header.
`include "quantized_global_average_pool_core_defines.svh"

module qgap_accum
    import qgap_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic signed [31:0] bias,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         sample,
    input  logic [7:0]         channel,
    input  logic               first_row,
    input  logic               last_row,
    input  qgap_qstat_t        qstat,
    output logic               push,
    output qgap_entry_t        push_entry
);

    logic [31:0]       sums_mem [MAX_CHANNELS];
    logic [31:0]       rd_data_reg;

    logic              a_valid_reg;
    logic [7:0]        a_sample_reg;
    logic [7:0]        a_channel_reg;
    logic [ADDR_W-1:0] a_addr_reg;
    logic              a_first_reg;
    logic              a_last_reg;

    // Write of the previous cycle, forwarded past the read port
    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [31:0]       fwd_acc_reg;

    logic              accept;
    logic              in_range;
    logic [ADDR_W-1:0] in_addr;
    logic [31:0]       base;
    logic [31:0]       acc_next;
    logic [Q_CNT_W:0]  committed;

    assign accept   = in_valid && !in_stall;
    assign in_range = (32'(channel) < MAX_CHANNELS);
    assign in_addr  = ADDR_W'(channel);

    // Credit check: queue level plus the word in flight must leave a slot
    assign committed = (Q_CNT_W + 1)'(qstat.level) + (Q_CNT_W + 1)'(a_valid_reg);
    assign in_stall  = (32'(committed) >= Q_DEPTH);

    // Sum update
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == a_addr_reg))
        begin
            base = fwd_acc_reg;
        end
        else
        begin
            base = rd_data_reg;
        end
        if (a_first_reg)
        begin
            acc_next = bias + {24'd0, a_sample_reg};
        end
        else
        begin
            acc_next = base + {24'd0, a_sample_reg};
        end
    end

    // Sum memory: read on accept, written back in the following cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= sums_mem[in_addr];
        end
        if (a_valid_reg)
        begin
            sums_mem[a_addr_reg] <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= accept && in_range;
            fwd_valid_reg <= a_valid_reg;
        end
    end

    // Payload stage, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_sample_reg  <= sample;
            a_channel_reg <= channel;
            a_addr_reg    <= in_addr;
            a_first_reg   <= first_row;
            a_last_reg    <= last_row;
        end
        fwd_addr_reg <= a_addr_reg;
        fwd_acc_reg  <= acc_next;
    end

    assign push             = a_valid_reg && a_last_reg;
    assign push_entry.channel = a_channel_reg;
    assign push_entry.acc     = acc_next;

    `QGAP_ASSERT_NEXT(a_last_pushes, accept && in_range && last_row, push, "last row word not queued")
    `QGAP_ASSERT(a_credit, push, 32'(qstat.level) < Q_DEPTH, "push without queue credit")
    `QGAP_ASSERT_NEXT(a_drop_range, accept && !in_range, !a_valid_reg, "out of range word kept")

endmodule

/* hdl/qgap_requant.sv */
// Back end: multiply, round, shift, clamp and offset of one channel sum per word.
// Depends on qgap_pkg and the assertion macro header.
`include "quantized_global_average_pool_core_defines.svh"

module qgap_requant
    import qgap_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  qgap_cfg_t   cfg,
    input  qgap_qstat_t qstat,
    input  qgap_entry_t head_entry,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_channel,
    output logic [7:0]  pooled_value
);

    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic [7:0]         ch1_reg, ch2_reg, ch3_reg, ch4_reg;
    logic signed [63:0] prod_reg;
    logic               neg_reg;
    logic [63:0]        sum_reg;
    logic [31:0]        shr_reg;
    logic [7:0]         pooled_reg;

    logic               rdy1, rdy2, rdy3, rdy4;
    logic signed [63:0] prod;
    logic [63:0]        sum_next;
    logic signed [63:0] shifted;
    logic signed [31:0] val;
    logic signed [31:0] lo32;
    logic signed [31:0] hi32;
    logic signed [31:0] clamp1;
    logic signed [31:0] clamp2;
    logic [7:0]         pooled_next;

    // Stall chain from the output register back to the queue
    assign rdy4 = !v4_reg || !out_stall;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign pop  = qstat.not_empty && rdy1;

    // Stage 1: 32x32 signed product
    assign prod = $signed(head_entry.acc) * $signed({1'b0, cfg.scale_multiplier});

    // Stage 2: negative correction and rounding, mod 2^64
    assign sum_next = prod_reg + {1'b0, cfg.rounding_term} - {63'd0, neg_reg};

    // Stage 3: arithmetic shift, keep low word
    assign shifted = $signed(sum_reg) >>> cfg.shift_amount;

    // Stage 4: clamp low first, then high, then zero point
    always_comb
    begin
        val    = $signed(shr_reg);
        lo32   = {{23{cfg.clamp_low[8]}}, cfg.clamp_low};
        hi32   = {{23{cfg.clamp_high[8]}}, cfg.clamp_high};
        clamp1 = (val < lo32) ? lo32 : val;
        clamp2 = (clamp1 > hi32) ? hi32 : clamp1;
        pooled_next = clamp2[7:0] + cfg.zero_offset;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= pop;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Payload stages, no reset
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            prod_reg <= prod;
            neg_reg  <= head_entry.acc[31];
            ch1_reg  <= head_entry.channel;
        end
        if (rdy2 && v1_reg)
        begin
            sum_reg <= sum_next;
            ch2_reg <= ch1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            shr_reg <= shifted[31:0];
            ch3_reg <= ch2_reg;
        end
        if (rdy4 && v3_reg)
        begin
            pooled_reg <= pooled_next;
            ch4_reg    <= ch3_reg;
        end
    end

    assign out_valid    = v4_reg;
    assign out_channel  = ch4_reg;
    assign pooled_value = pooled_reg;

    `QGAP_ASSERT_NEXT(a_pop_loads, pop, v1_reg, "popped word not in stage one")
    `QGAP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(ch4_reg), "stalled result lost")
    `QGAP_ASSERT(a_no_pop_stall, v1_reg && !rdy2, !pop, "pop into blocked stage")

endmodule

/* hdl/quantized_global_average_pool_core.sv */
// Top level of the uint8 global average pooling core with requantization.
// Depends on qgap_pkg, qgap_accum, qgap_fifo and qgap_requant.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  input   | in_valid / in_stall | sample, channel, first_row, last_row
//  output  | out_valid/out_stall | out_channel, pooled_value
//  config  | cfg_write           | cfg_index, cfg_data
//
// One word is taken per cycle while in_stall is low; the sum memory's
// read-modify-write with forwarding of the previous write sets that rate.
// A result passes the accumulate register, the queue and the requantize stages.
// Reset clears control state and loads the register defaults; sums are
// undefined until a first-row word writes them.
// Output stalls fill the 4-entry queue; in_stall rises once its level plus the word in flight reaches it.

module quantized_global_average_pool_core
    import qgap_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [62:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  sample,
    input  logic [7:0]  channel,
    input  logic        first_row,
    input  logic        last_row,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_channel,
    output logic [7:0]  pooled_value
);

    logic signed [31:0] bias_reg;
    qgap_cfg_t          cfg_reg;
    qgap_qstat_t        qstat;
    qgap_entry_t        push_entry;
    qgap_entry_t        head_entry;
    logic               push;
    logic               pop;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg                 <= 32'sd0;
            cfg_reg.scale_multiplier <= 31'd1073741824;
            cfg_reg.rounding_term    <= 63'd0;
            cfg_reg.shift_amount     <= 6'd31;
            cfg_reg.clamp_low        <= -9'sd128;
            cfg_reg.clamp_high       <= 9'sd127;
            cfg_reg.zero_offset      <= 8'd128;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BIAS:             bias_reg                 <= cfg_data[31:0];
                REG_SCALE_MULTIPLIER: cfg_reg.scale_multiplier <= cfg_data[30:0];
                REG_ROUNDING_TERM:    cfg_reg.rounding_term    <= cfg_data;
                REG_SHIFT_AMOUNT:     cfg_reg.shift_amount     <= cfg_data[5:0];
                REG_CLAMP_LOW:        cfg_reg.clamp_low        <= cfg_data[8:0];
                REG_CLAMP_HIGH:       cfg_reg.clamp_high       <= cfg_data[8:0];
                REG_ZERO_OFFSET:      cfg_reg.zero_offset      <= cfg_data[7:0];
                default:              ;
            endcase
        end
    end

    // Front: accept and accumulate
    qgap_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .bias       (bias_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .channel    (channel),
        .first_row  (first_row),
        .last_row   (last_row),
        .qstat      (qstat),
        .push       (push),
        .push_entry (push_entry)
    );

    // Queue of finished sums
    qgap_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .status     (qstat)
    );

    // Back: requantize and deliver
    qgap_requant u_requant (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .qstat        (qstat),
        .head_entry   (head_entry),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_channel  (out_channel),
        .pooled_value (pooled_value)
    );

endmodule

/* tb/qgap_checker.sv */
`timescale 1ns / 1ps
// Result checker for the pooling core: follows config writes and accepted words,
// keeps its own channel sums and settings, and compares each pooled result.
// Depends on qgap_pkg for the register codes and the channel count.
module qgap_checker
    import qgap_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [62:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  sample,
    input  logic [7:0]  channel,
    input  logic        first_row,
    input  logic        last_row,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  out_channel,
    input  logic [7:0]  pooled_value,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [7:0] chan;
        logic [7:0] value;
    } pool_word_t;

    // Local copy of the requantization settings
    logic signed [31:0] bias_r;
    logic [30:0]        mult_r;
    logic [62:0]        round_r;
    logic [5:0]         shift_r;
    logic signed [8:0]  clamp_lo_r;
    logic signed [8:0]  clamp_hi_r;
    logic [7:0]         zero_r;

    logic [31:0] channel_sum [MAX_CHANNELS];
    pool_word_t  expected_words [$];
    pool_word_t  want_word;
    logic [31:0] new_sum;
    int          mismatches;

    // Scale, round, shift, clamp and offset one channel sum
    function automatic logic [7:0] requantize_sum(input logic [31:0] acc_bits);
        logic signed [63:0] scaled;
        logic signed [31:0] v;
        scaled = $signed({{32{acc_bits[31]}}, acc_bits}) * $signed({33'b0, mult_r});
        if (acc_bits[31])
            scaled = scaled - 64'sd1;
        // 64-bit wrap before the shift
        scaled = scaled + $signed({1'b0, round_r});
        scaled = scaled >>> shift_r;
        v = scaled[31:0];
        // max against the low bound first, so crossed bounds give the high one
        if (v < clamp_lo_r)
            v = clamp_lo_r;
        if (v > clamp_hi_r)
            v = clamp_hi_r;
        return v[7:0] + zero_r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_r     = '0;
            mult_r     = 31'd1073741824;
            round_r    = '0;
            shift_r    = 6'd31;
            clamp_lo_r = -9'sd128;
            clamp_hi_r = 9'sd127;
            zero_r     = 8'd128;
            expected_words.delete();
            mismatches = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            // register writes
            if (cfg_write)
            begin
                case (qgap_reg_t'(cfg_index))
                    REG_BIAS:             bias_r     = cfg_data[31:0];
                    REG_SCALE_MULTIPLIER: mult_r     = cfg_data[30:0];
                    REG_ROUNDING_TERM:    round_r    = cfg_data[62:0];
                    REG_SHIFT_AMOUNT:     shift_r    = cfg_data[5:0];
                    REG_CLAMP_LOW:        clamp_lo_r = cfg_data[8:0];
                    REG_CLAMP_HIGH:       clamp_hi_r = cfg_data[8:0];
                    REG_ZERO_OFFSET:      zero_r     = cfg_data[7:0];
                    default: ;
                endcase
            end

            // result side: compare against the oldest expectation
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected result word, channel %0d value %0d",
                             $time, out_channel, pooled_value);
                    mismatches++;
                end
                else
                begin
                    want_word = expected_words.pop_front();
                    if (out_channel !== want_word.chan)
                    begin
                        $display("%0t: out_channel expected %0d, actual %0d",
                                 $time, want_word.chan, out_channel);
                        mismatches++;
                    end
                    if (pooled_value !== want_word.value)
                    begin
                        $display("%0t: pooled_value (channel %0d) expected %0d, actual %0d",
                                 $time, want_word.chan, want_word.value, pooled_value);
                        mismatches++;
                    end
                end
            end

            // input side: accumulate, and predict a result on the last row
            if (in_valid && !in_stall)
            begin
                if (first_row)
                    new_sum = bias_r + {24'b0, sample};
                else
                    new_sum = channel_sum[channel] + {24'b0, sample};
                channel_sum[channel] = new_sum;
                if (last_row)
                    expected_words.push_back('{chan: channel, value: requantize_sum(new_sum)});
            end

            fail_count <= mismatches;
            pending    <= expected_words.size();
        end
    end

endmodule

/* tb/quantized_global_average_pool_core_tb.sv */
`timescale 1ns / 1ps
// Top of the pooling core testbench: clock, reset, stimulus and verdict.
// Depends on qgap_pkg, the core and qgap_checker.
module quantized_global_average_pool_core_tb
    import qgap_pkg::*;
();

    localparam int CLK_PERIOD       = 10;
    localparam int NUM_PHASES       = 10;
    localparam int RANDOM_PER_PHASE = 45;
    localparam int FLUSH_CYCLES     = 10;
    localparam int END_CYCLES       = 20;
    localparam int WATCHDOG_LIMIT   = 3000;

    typedef struct {
        logic signed [31:0] bias;
        logic [30:0]        mult;
        logic [62:0]        round_add;
        logic [5:0]         shift;
        logic signed [8:0]  clamp_low;
        logic signed [8:0]  clamp_high;
        logic [7:0]         zero_point;
    } pool_settings_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [62:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  sample;
    logic [7:0]  channel;
    logic        first_row;
    logic        last_row;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_channel;
    logic [7:0]  pooled_value;
    int          fail_count;
    int          pending;

    int             idle_pct;
    int             stall_pct;
    int             quiet_cycles = 0;
    int             phase;
    int             k;
    int             t;
    logic [255:0]   ch_written;
    logic [7:0]     rnd_ch;
    logic           rnd_first;
    pool_settings_t st;

    quantized_global_average_pool_core dut (.*);

    qgap_checker result_check (.*);

    always #(CLK_PERIOD / 2) clk = ~clk;

    // receiver stalls at the rate of the current phase
    always @(posedge clk)
        out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);

    // watchdog on cycles with no accepted word, delivered result or write
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one word, with an optional idle gap first, and hold it until taken
    task automatic send_word(input logic [7:0] s, input logic [7:0] ch,
                             input logic f, input logic l);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct);
        end
        in_valid  <= 1'b1;
        sample    <= s;
        channel   <= ch;
        first_row <= f;
        last_row  <= l;
        if (f)
            ch_written[ch] = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Stop sending until every predicted result is out, then let the pipe empty
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (FLUSH_CYCLES) @(posedge clk);
    endtask

    // One register write; cfg_write is lowered by the caller after the batch
    task automatic write_reg(input qgap_reg_t idx, input logic [62:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    initial
    begin
        in_valid   = 1'b0;
        sample     = '0;
        channel    = '0;
        first_row  = 1'b0;
        last_row   = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = REG_BIAS;
        cfg_data   = '0;
        ch_written = '0;
        idle_pct   = 0;
        stall_pct  = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 72; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 72; end
                default: begin idle_pct = 34; stall_pct = 34; end
            endcase

            if (phase == 0)
            begin
                // directed words under the reset settings
                send_word(8'd0,   8'd0,   1'b1, 1'b1);  // first and last together
                send_word(8'd255, 8'd255, 1'b1, 1'b1);
                send_word(8'd255, 8'd1,   1'b1, 1'b0);  // two interleaved channels
                send_word(8'd0,   8'd2,   1'b1, 1'b0);
                send_word(8'd255, 8'd1,   1'b0, 1'b0);
                send_word(8'd1,   8'd2,   1'b0, 1'b0);
                send_word(8'd255, 8'd1,   1'b0, 1'b0);
                send_word(8'd0,   8'd2,   1'b0, 1'b1);
                send_word(8'd255, 8'd1,   1'b0, 1'b1);  // saturates high
                send_word(8'd85,  8'd170, 1'b1, 1'b0);
                send_word(8'd170, 8'd85,  1'b1, 1'b0);
                send_word(8'd170, 8'd170, 1'b0, 1'b1);
                send_word(8'd85,  8'd85,  1'b0, 1'b1);
                send_word(8'd7,   8'd0,   1'b0, 1'b1);  // keeps adding after a result
                send_word(8'd200, 8'd1,   1'b1, 1'b0);  // restart mid-sequence
                send_word(8'd100, 8'd1,   1'b1, 1'b1);
            end
            else
            begin
                wait_for_drain();
                case (phase)
                    1:
                    begin
                        // most negative bias, widest clamps, full shift
                        st.bias = 32'sh8000_0000;  st.mult = 31'h7FFF_FFFF;
                        st.round_add = 63'h4000_0000_0000_0000;  st.shift = 6'd63;
                        st.clamp_low = -9'sd255;  st.clamp_high = 9'sd255;
                        st.zero_point = 8'd0;
                    end
                    2:
                    begin
                        // wrapping bias, zero multiplier, crossed clamps
                        st.bias = 32'sh7FFF_FFFF;  st.mult = 31'd0;
                        st.round_add = 63'd0;  st.shift = 6'd0;
                        st.clamp_low = 9'sd255;  st.clamp_high = -9'sd255;
                        st.zero_point = 8'd255;
                    end
                    3:
                    begin
                        // rounding term large enough to wrap the 64-bit sum
                        st.bias = -32'sd1000;  st.mult = 31'h4000_0000;
                        st.round_add = 63'h7FFF_FFFF_FFFF_FFFF;  st.shift = 6'd40;
                        st.clamp_low = -9'sd128;  st.clamp_high = 9'sd127;
                        st.zero_point = 8'd128;
                    end
                    4:
                    begin
                        // plain averaging with round-to-nearest
                        st.bias = 32'sd0;  st.mult = 31'h2000_0000;
                        st.round_add = 63'h4000_0000;  st.shift = 6'd31;
                        st.clamp_low = -9'sd128;  st.clamp_high = 9'sd127;
                        st.zero_point = 8'd128;
                    end
                    default:
                    begin
                        st.bias = ($urandom_range(0, 1) != 0) ? 32'($urandom)
                                  : 32'($urandom_range(0, 2000)) - 32'd1000;
                        st.mult = 31'($urandom);
                        st.shift = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                   : 6'($urandom_range(24, 40));
                        case ($urandom_range(0, 2))
                            0: st.round_add = '0;
                            1: st.round_add = (st.shift == 0) ? 63'd0
                                              : 63'd1 << (st.shift - 6'd1);
                            default: st.round_add = {31'($urandom), 32'($urandom)};
                        endcase
                        t = $urandom_range(0, 510) - 255;
                        st.clamp_low = t[8:0];
                        t = $urandom_range(0, 510) - 255;
                        st.clamp_high = t[8:0];
                        // mostly ordered bounds, crossed now and then
                        if (st.clamp_low > st.clamp_high && $urandom_range(0, 3) != 0)
                        begin
                            st.clamp_low  = st.clamp_high;
                            st.clamp_high = t[8:0];
                            st.clamp_high = st.clamp_low == st.clamp_high ? st.clamp_high
                                            : st.clamp_high;
                        end
                        st.zero_point = 8'($urandom_range(0, 255));
                    end
                endcase
                write_reg(REG_BIAS,             {31'b0, st.bias});
                write_reg(REG_SCALE_MULTIPLIER, {32'b0, st.mult});
                write_reg(REG_ROUNDING_TERM,    st.round_add);
                write_reg(REG_SHIFT_AMOUNT,     {57'b0, st.shift});
                write_reg(REG_CLAMP_LOW,        {54'b0, st.clamp_low});
                write_reg(REG_CLAMP_HIGH,       {54'b0, st.clamp_high});
                write_reg(REG_ZERO_OFFSET,      {55'b0, st.zero_point});
                cfg_write <= 1'b0;
            end

            // random rows: mostly a few busy channels, sometimes any channel;
            // a channel never seen before always starts with a first row
            for (k = 0; k < RANDOM_PER_PHASE; k++)
            begin
                rnd_ch = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                         : 8'($urandom_range(0, 7));
                rnd_first = !ch_written[rnd_ch] || ($urandom_range(0, 5) == 0);
                send_word(8'($urandom_range(0, 255)), rnd_ch, rnd_first,
                          $urandom_range(0, 3) == 0);
            end
        end

        wait_for_drain();
        repeat (END_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
